/* hdl/bidr_pkg.sv */
// ----------------------------------------------------------------------------
// bidr_pkg
// shared types, constants and the bit-pair byte rebuild function
// ----------------------------------------------------------------------------
package bidr_pkg;

    localparam int MAX_ROW_WORDS_DEF = 1024;

    localparam int PIXEL_BYTES_W = 3;
    localparam int ROW_WORDS_W   = 11;
    localparam int ROW_COUNT_W   = 16;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [PIXEL_BYTES_W-1:0] PIXEL_BYTES_RST = 3'd4;
    localparam logic [ROW_WORDS_W-1:0]   ROW_WORDS_RST   = 11'd1024;
    localparam logic [ROW_COUNT_W-1:0]   ROW_COUNT_RST   = 16'd1;

    localparam logic [7:0] BYTE_MASK = 8'hFF;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PIXEL_BYTES = 2'd0,
        CFG_ROW_WORDS   = 2'd1,
        CFG_ROW_COUNT   = 2'd2
    } t_cfg_idx;

    // per-word filter control, decided when the word is taken in
    typedef struct packed {
        logic row_first;   // word belongs to the first row of the frame
        logic has_prev;    // not the first word of its row
        logic pb_three;    // three bytes per pixel
    } t_word_ctl;

    // gather bit pair j of each quarter byte, then unfold the sign-like low bit
    function automatic logic [7:0] rebuild_byte(
        input logic [7:0] a,
        input logic [7:0] b,
        input logic [7:0] c,
        input logic [7:0] d,
        input logic [1:0] j
    );
        logic [7:0] v;
        logic [2:0] sh;
        sh = {j, 1'b0};
        v  = {a[sh +: 2], b[sh +: 2], c[sh +: 2], d[sh +: 2]};
        if (v[0]) begin
            return {1'b0, v[7:1]} ^ BYTE_MASK;
        end
        return {1'b0, v[7:1]};
    endfunction

endpackage

/* hdl/bitpair_interleave_delta_restore_top.sv */
// ----------------------------------------------------------------------------
// bitpair_interleave_delta_restore_top
// bit-pair de-interleave and delta restore, one four-byte word per transaction
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+---------------------------
//  in       | input     | i_in_valid / o_in_stall    | quarter_a..d_byte
//  out      | output    | o_out_valid / i_out_stall  | byte_zero..three, row/frame end
//  cfg      | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  one word per cycle sustained while the output does not stall
//  stage one holds the word and the registered line store read, stage two the result
//  the line store has one write and one read port; the previous word is forwarded
//  when it lands in the slot being read (one-word rows)
//  synchronous active-low reset clears control and restores register defaults;
//  the line store is not cleared
//  a stall on the output backs up into o_in_stall in the same cycle
// ----------------------------------------------------------------------------
module bitpair_interleave_delta_restore_top
    import bidr_pkg::*;
#(
    parameter int MAX_ROW_WORDS = MAX_ROW_WORDS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    // configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,

    // input words
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [7:0]             i_quarter_a_byte,
    input  logic [7:0]             i_quarter_b_byte,
    input  logic [7:0]             i_quarter_c_byte,
    input  logic [7:0]             i_quarter_d_byte,

    // restored words
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [7:0]             o_byte_zero,
    output logic [7:0]             o_byte_one,
    output logic [7:0]             o_byte_two,
    output logic [7:0]             o_byte_three,
    output logic                   o_row_end,
    output logic                   o_frame_end
);

    // word position width and compare width
    localparam int WP_W  = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1;
    localparam int CMP_W = (WP_W + 1 > ROW_WORDS_W + 1) ? WP_W + 1 : ROW_WORDS_W + 1;

    // configuration registers
    logic [PIXEL_BYTES_W-1:0] r_pixel_bytes;
    logic [ROW_WORDS_W-1:0]   r_row_words;
    logic [ROW_COUNT_W-1:0]   r_row_count;

    // position state
    logic [WP_W-1:0]          r_wp, n_wp;
    logic [ROW_COUNT_W-1:0]   r_rp, n_rp;

    // stage one: input register
    logic                     r_in_valid;
    logic [7:0]               r_a, r_b, r_c, r_d;
    t_word_ctl                r_ctl;
    logic [WP_W-1:0]          r_slot;
    logic                     r_row_end;
    logic                     r_frame_end;
    logic [31:0]              r_above_mem;
    logic                     r_fwd;
    logic [31:0]              r_fwd_word;

    // stage two: output register
    logic                     r_out_valid;
    logic [31:0]              r_out_word;
    logic                     r_out_row_end;
    logic                     r_out_frame_end;

    // running state
    logic [31:0]              r_prev;
    logic [31:0]              line_store [MAX_ROW_WORDS];

    logic                     in_accept;
    logic                     fire;
    logic [CMP_W-1:0]         rw_raw;
    logic [CMP_W-1:0]         rw_eff;
    logic [CMP_W-1:0]         wp_p1;
    logic [ROW_COUNT_W:0]     rc_eff;
    logic [ROW_COUNT_W:0]     rp_p1;
    logic                     row_end;
    logic                     frame_end;
    t_word_ctl                ctl;
    logic [31:0]              above_word;
    logic [31:0]              word;

    // stage one empties when its word moves to the output register
    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // row and frame bookkeeping for the word being taken in
    always_comb begin
        rw_raw = (r_row_words == '0) ? CMP_W'(1) : CMP_W'(r_row_words);
        rw_eff = (rw_raw > CMP_W'(MAX_ROW_WORDS)) ? CMP_W'(MAX_ROW_WORDS) : rw_raw;
        wp_p1  = CMP_W'(r_wp) + CMP_W'(1);
        rc_eff = (r_row_count == '0) ? (ROW_COUNT_W+1)'(1) : (ROW_COUNT_W+1)'(r_row_count);
        rp_p1  = (ROW_COUNT_W+1)'(r_rp) + (ROW_COUNT_W+1)'(1);

        row_end   = (wp_p1 >= rw_eff);
        frame_end = row_end && (rp_p1 >= rc_eff);

        ctl.row_first = (r_rp == '0);
        ctl.has_prev  = (r_wp != '0);
        // out-of-range pixel sizes clamp to the nearest of three or four
        ctl.pb_three  = (r_pixel_bytes <= PIXEL_BYTES_W'(3));

        n_wp = r_wp;
        n_rp = r_rp;
        if (row_end) begin
            n_wp = '0;
            n_rp = frame_end ? '0 : rp_p1[ROW_COUNT_W-1:0];
        end else begin
            n_wp = wp_p1[WP_W-1:0];
        end
    end

    // configuration and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_bytes <= PIXEL_BYTES_RST;
            r_row_words   <= ROW_WORDS_RST;
            r_row_count   <= ROW_COUNT_RST;
            r_wp          <= '0;
            r_rp          <= '0;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_prev        <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_PIXEL_BYTES: r_pixel_bytes <= i_cfg_data[PIXEL_BYTES_W-1:0];
                    CFG_ROW_WORDS:   r_row_words   <= i_cfg_data[ROW_WORDS_W-1:0];
                    CFG_ROW_COUNT:   r_row_count   <= i_cfg_data[ROW_COUNT_W-1:0];
                    default: ;
                endcase
            end

            if (in_accept) begin
                r_wp       <= n_wp;
                r_rp       <= n_rp;
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end

            if (fire) begin
                r_out_valid <= 1'b1;
                // left neighbor restarts at zero on every row
                r_prev      <= r_row_end ? '0 : word;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // stage one payload, line store read and same-slot forward
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_a         <= i_quarter_a_byte;
            r_b         <= i_quarter_b_byte;
            r_c         <= i_quarter_c_byte;
            r_d         <= i_quarter_d_byte;
            r_ctl       <= ctl;
            r_slot      <= r_wp;
            r_row_end   <= row_end;
            r_frame_end <= frame_end;
            r_above_mem <= line_store[r_wp];
            r_fwd       <= fire && (r_slot == r_wp);
            r_fwd_word  <= word;
        end
    end

    // line store write of the finished word
    always_ff @(posedge i_clk) begin
        if (fire) begin
            line_store[r_slot] <= word;
        end
    end

    assign above_word = r_fwd ? r_fwd_word : r_above_mem;

    bidr_filter u_filter (
        .i_a          (r_a),
        .i_b          (r_b),
        .i_c          (r_c),
        .i_d          (r_d),
        .i_ctl        (r_ctl),
        .i_prev_word  (r_prev),
        .i_above_word (above_word),
        .o_word       (word)
    );

    // stage two payload
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_word      <= word;
            r_out_row_end   <= r_row_end;
            r_out_frame_end <= r_frame_end;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_byte_zero  = r_out_word[7:0];
    assign o_byte_one   = r_out_word[15:8];
    assign o_byte_two   = r_out_word[23:16];
    assign o_byte_three = r_out_word[31:24];
    assign o_row_end    = r_out_row_end;
    assign o_frame_end  = r_out_frame_end;

endmodule

/* hdl/bidr_filter.sv */
// ----------------------------------------------------------------------------
// bidr_filter
// byte rebuild and delta restore for one four-byte word
// ----------------------------------------------------------------------------
module bidr_filter
    import bidr_pkg::*;
(
    input  logic [7:0]  i_a,
    input  logic [7:0]  i_b,
    input  logic [7:0]  i_c,
    input  logic [7:0]  i_d,
    input  t_word_ctl   i_ctl,
    input  logic [31:0] i_prev_word,
    input  logic [31:0] i_above_word,
    output logic [31:0] o_word
);

    logic [7:0]  raw   [4];
    logic [7:0]  res   [4];
    logic [31:0] prev_eff;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            raw[k] = rebuild_byte(i_a, i_b, i_c, i_d, 2'(k));
        end
        prev_eff = i_ctl.has_prev ? i_prev_word : '0;

        if (!i_ctl.row_first) begin
            // later rows: add the byte above
            for (int k = 0; k < 4; k++) begin
                res[k] = raw[k] + i_above_word[8*k +: 8];
            end
        end else if (i_ctl.pb_three) begin
            // 24-bit pixels: left neighbor straddles the word boundary
            res[0] = raw[0] + prev_eff[15:8];
            res[1] = raw[1] + prev_eff[23:16];
            res[2] = raw[2] + prev_eff[31:24];
            res[3] = raw[3] + res[0];
        end else begin
            for (int k = 0; k < 4; k++) begin
                res[k] = raw[k] + prev_eff[8*k +: 8];
            end
        end

        o_word = {res[3], res[2], res[1], res[0]};
    end

endmodule

/* hdl/bidr_checker.sv */
// ----------------------------------------------------------------------------
// bidr_checker
// port-level checks on the restore block, bound to the top level
// ----------------------------------------------------------------------------
module bidr_checker
    import bidr_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_cfg_valid,
    input logic                   o_cfg_ready,
    input logic [CFG_INDEX_W-1:0] i_cfg_index,
    input logic [CFG_DATA_W-1:0]  i_cfg_data,
    input logic                   i_in_valid,
    input logic                   o_in_stall,
    input logic [7:0]             i_quarter_a_byte,
    input logic [7:0]             i_quarter_b_byte,
    input logic [7:0]             i_quarter_c_byte,
    input logic [7:0]             i_quarter_d_byte,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic [7:0]             o_byte_zero,
    input logic [7:0]             o_byte_one,
    input logic [7:0]             o_byte_two,
    input logic [7:0]             o_byte_three,
    input logic                   o_row_end,
    input logic                   o_frame_end
);

    // a stalled result stays and holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_byte_zero) && $stable(o_byte_one)
             && $stable(o_byte_two) && $stable(o_byte_three)
             && $stable(o_row_end) && $stable(o_frame_end)))
        else $error("stalled result changed");

    // a frame always closes on a row boundary
    a_frame_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end) |-> o_row_end)
        else $error("frame end without row end");

    // input back-pressure comes only from a stalled full output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled with output free");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind bitpair_interleave_delta_restore_top bidr_checker u_checker (.*);
